// ===== rtl/core/hsv_pkg.sv =====
// shared types, codes and constants of the rgb to hsv converter
// no dependencies; imported by every module of the block
package hsv_pkg;

    // hue units per 60 degree sector and per full turn, in 1/64 degree
    localparam logic [15:0] HUE_SECTOR_UNITS = 16'd3840;
    localparam logic [15:0] HUE_FULL_TURN    = 16'd23040;

    // long division layout: 16 quotient bits over 8-bit divisors
    localparam int DIV_QUO_BITS   = 16;
    localparam int DIV_BITS_STAGE = 4;
    localparam int DIV_STAGES     = DIV_QUO_BITS / DIV_BITS_STAGE;

    // hue sector codes, in tie order
    localparam logic [1:0] SECT_RED   = 2'd0;
    localparam logic [1:0] SECT_GREEN = 2'd1;
    localparam logic [1:0] SECT_BLUE  = 2'd2;

    typedef struct packed {
        logic [7:0] red;
        logic [7:0] green;
        logic [7:0] blue;
    } hsv_pixel_t;

    typedef struct packed {
        logic [14:0] hue_q6;
        logic [15:0] sat_q16;
        logic [7:0]  value_byte;
    } hsv_result_t;

    // one divider lane: work word holds remainder over dividend bits / quotient
    typedef struct packed {
        logic [23:0] work;
        logic [7:0]  den;
    } hsv_lane_t;

    // per-pixel facts carried alongside the divisions
    typedef struct packed {
        logic       grey;
        logic       neg;
        logic [1:0] sector;
        logic [7:0] value;
    } hsv_side_t;

    typedef struct packed {
        hsv_lane_t sat;
        hsv_lane_t hue;
        hsv_side_t side;
    } hsv_div_pkt_t;

endpackage

// ===== rtl/core/hsv_prep.sv =====
// front end: max/min, sector and difference, then division operands
// depends on hsv_pkg
module hsv_prep
    import hsv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  hsv_pixel_t   in_pixel,
    output logic         out_valid,
    input  logic         out_ready,
    output hsv_div_pkt_t out_pkt
);

    logic        a_valid_reg;
    logic [7:0]  a_max_reg;
    logic [7:0]  a_delta_reg;
    logic [1:0]  a_sector_reg;
    logic        a_neg_reg;
    logic [7:0]  a_absdiff_reg;
    logic        a_ready;

    logic        b_valid_reg;
    hsv_div_pkt_t b_pkt_reg;
    hsv_div_pkt_t b_pkt_next;
    logic        b_ready;

    logic [7:0]  max_v;
    logic [7:0]  min_v;
    logic [1:0]  sector_v;
    logic [8:0]  diff_v;
    logic [8:0]  diff_neg;
    logic [19:0] hue_num;

    // channel max/min and sector, red wins ties over green over blue
    always_comb begin
        max_v = in_pixel.red;
        min_v = in_pixel.red;
        if (in_pixel.green > max_v) max_v = in_pixel.green;
        if (in_pixel.blue > max_v)  max_v = in_pixel.blue;
        if (in_pixel.green < min_v) min_v = in_pixel.green;
        if (in_pixel.blue < min_v)  min_v = in_pixel.blue;
        priority if (in_pixel.red == max_v) begin
            sector_v = SECT_RED;
            diff_v   = {1'b0, in_pixel.green} - {1'b0, in_pixel.blue};
        end else if (in_pixel.green == max_v) begin
            sector_v = SECT_GREEN;
            diff_v   = {1'b0, in_pixel.blue} - {1'b0, in_pixel.red};
        end else begin
            sector_v = SECT_BLUE;
            diff_v   = {1'b0, in_pixel.red} - {1'b0, in_pixel.green};
        end
        diff_neg = 9'd0 - diff_v;
    end

    assign a_ready  = !a_valid_reg || b_ready;
    assign b_ready  = !b_valid_reg || out_ready;
    assign in_ready = a_ready;

    // stage a: extremes and sector
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            a_valid_reg <= 1'b0;
        end else if (a_ready) begin
            a_valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (a_ready && in_valid) begin
            a_max_reg     <= max_v;
            a_delta_reg   <= max_v - min_v;
            a_sector_reg  <= sector_v;
            a_neg_reg     <= diff_v[8];
            a_absdiff_reg <= diff_v[8] ? diff_neg[7:0] : diff_v[7:0];
        end
    end

    // stage b: dividends delta*65535 and |diff|*3840
    always_comb begin
        hue_num = {a_absdiff_reg, 12'd0} - {4'd0, a_absdiff_reg, 8'd0};
        b_pkt_next.sat.work   = {a_delta_reg, 16'd0} - {16'd0, a_delta_reg};
        b_pkt_next.sat.den    = a_max_reg;
        b_pkt_next.hue.work   = {4'd0, hue_num};
        b_pkt_next.hue.den    = a_delta_reg;
        b_pkt_next.side.grey   = (a_delta_reg == 8'd0);
        b_pkt_next.side.neg    = a_neg_reg;
        b_pkt_next.side.sector = a_sector_reg;
        b_pkt_next.side.value  = a_max_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else if (b_ready) begin
            b_valid_reg <= a_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (b_ready && a_valid_reg) begin
            b_pkt_reg <= b_pkt_next;
        end
    end

    assign out_valid = b_valid_reg;
    assign out_pkt   = b_pkt_reg;

endmodule

// ===== rtl/core/hsv_div_stage.sv =====
// one divider stage: a few restoring long-division steps on both lanes
// depends on hsv_pkg
module hsv_div_stage
    import hsv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  hsv_div_pkt_t in_pkt,
    output logic         out_valid,
    input  logic         out_ready,
    output hsv_div_pkt_t out_pkt
);

    logic         valid_reg;
    hsv_div_pkt_t pkt_reg;
    hsv_div_pkt_t pkt_next;

    // one quotient bit: compare-subtract the partial remainder with the divisor
    function automatic hsv_lane_t div_step(input hsv_lane_t lane);
        hsv_lane_t  res;
        logic [8:0] part;
        logic       qbit;
        part = {lane.work[23:16], lane.work[15]};
        qbit = (part >= {1'b0, lane.den});
        if (qbit) part = part - {1'b0, lane.den};
        res.work = {part[7:0], lane.work[14:0], qbit};
        res.den  = lane.den;
        return res;
    endfunction

    always_comb begin
        pkt_next = in_pkt;
        for (int i = 0; i < DIV_BITS_STAGE; i++) begin
            pkt_next.sat = div_step(pkt_next.sat);
            pkt_next.hue = div_step(pkt_next.hue);
        end
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pkt_reg <= pkt_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_pkt   = pkt_reg;

endmodule

// ===== rtl/core/hsv_finish.sv =====
// back end: hue assembly with floor and wrap, grey override, output register
// depends on hsv_pkg
module hsv_finish
    import hsv_pkg::*;
(
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         in_valid,
    output logic         in_ready,
    input  hsv_div_pkt_t in_pkt,
    output logic         out_valid,
    input  logic         out_ready,
    output hsv_result_t  out_result
);

    logic        valid_reg;
    hsv_result_t result_reg;
    hsv_result_t result_next;

    logic [15:0] base;
    logic [15:0] wrap;
    logic [15:0] mag;
    logic [15:0] hue_sum;
    logic        rem_nz;

    // hue = 2*sector*3840 + floor(diff*3840/delta), plus a turn when negative in the red sector
    always_comb begin
        rem_nz = |in_pkt.hue.work[23:16];
        unique case (in_pkt.side.sector)
            SECT_RED:   base = 16'd0;
            SECT_GREEN: base = HUE_SECTOR_UNITS + HUE_SECTOR_UNITS;
            SECT_BLUE:  base = HUE_SECTOR_UNITS + HUE_SECTOR_UNITS
                               + HUE_SECTOR_UNITS + HUE_SECTOR_UNITS;
            default:    base = 16'd0;
        endcase
        wrap = (in_pkt.side.neg && in_pkt.side.sector == SECT_RED) ? HUE_FULL_TURN : 16'd0;
        // negative fractions round toward minus infinity
        mag = in_pkt.hue.work[15:0] + {15'd0, in_pkt.side.neg & rem_nz};
        hue_sum = in_pkt.side.neg ? (base + wrap - mag) : (base + mag);
        if (in_pkt.side.grey) begin
            result_next.hue_q6  = 15'd0;
            result_next.sat_q16 = 16'd0;
        end else begin
            result_next.hue_q6  = hue_sum[14:0];
            result_next.sat_q16 = in_pkt.sat.work[15:0];
        end
        result_next.value_byte = in_pkt.side.value;
    end

    assign in_ready = !valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (in_ready) begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            result_reg <= result_next;
        end
    end

    assign out_valid  = valid_reg;
    assign out_result = result_reg;

endmodule

// ===== rtl/core/rgb_to_hsv_converter.sv =====
// top level of the rgb to hsv converter: prep, divider stages, finish
// depends on hsv_pkg, hsv_prep, hsv_div_stage, hsv_finish
//
//   channel  | ports                      | payload
//   ---------+----------------------------+---------------------------------
//   input    | s_valid, s_ready, s_pixel  | red, green, blue (8 bits each)
//   result   | m_valid, m_ready, m_result | hue_q6, sat_q16, value_byte
//
// one transaction per clock sustained while m_ready is high; 2 prep stages,
// 4 divider stages of 4 quotient bits each, 1 output register
// the 16-bit quotient of the saturation and hue divisions sets the depth
// each stage holds its own valid bit and stalls only when full and blocked,
// so bubbles close up while m_ready is low
// aresetn clears the valid bits only; no other state
module rgb_to_hsv_converter
    import hsv_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  hsv_pixel_t  s_pixel,
    output logic        m_valid,
    input  logic        m_ready,
    output hsv_result_t m_result
);

    logic         div_valid [DIV_STAGES+1];
    logic         div_ready [DIV_STAGES+1];
    hsv_div_pkt_t div_pkt   [DIV_STAGES+1];

    // extremes, sector and dividends
    hsv_prep u_prep (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_pixel  (s_pixel),
        .out_valid (div_valid[0]),
        .out_ready (div_ready[0]),
        .out_pkt   (div_pkt[0])
    );

    // pipelined long division for saturation and hue
    for (genvar k = 0; k < DIV_STAGES; k++) begin : g_div
        hsv_div_stage u_div_stage (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (div_valid[k]),
            .in_ready  (div_ready[k]),
            .in_pkt    (div_pkt[k]),
            .out_valid (div_valid[k+1]),
            .out_ready (div_ready[k+1]),
            .out_pkt   (div_pkt[k+1])
        );
    end

    // hue assembly and output register
    hsv_finish u_finish (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (div_valid[DIV_STAGES]),
        .in_ready   (div_ready[DIV_STAGES]),
        .in_pkt     (div_pkt[DIV_STAGES]),
        .out_valid  (m_valid),
        .out_ready  (m_ready),
        .out_result (m_result)
    );

endmodule
